// ----- rtl/camera_projection_with_distortion_macros.svh -----
// ----------------------------------------------------------------------------
// Camera projection assertion macros
// Shared implication checks for the projection pipeline checker.
// ----------------------------------------------------------------------------
`ifndef CAMERA_PROJECTION_WITH_DISTORTION_MACROS_SVH
`define CAMERA_PROJECTION_WITH_DISTORTION_MACROS_SVH

// same-cycle implication, disabled during reset
`define CPD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("projection check failed");

// next-cycle implication, disabled during reset
`define CPD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("projection check failed");

`endif

// ----- rtl/cpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Camera projection package
// Types, register codes, pipeline depths and fixed-point helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpd_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K1      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_K2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_K3      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P1      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_P2      = 3'd6;

    localparam logic [DATA_W-1:0] ONE_Q24 = 32'h0100_0000;

    localparam int DIV_LAT  = DATA_W + 1;
    localparam int DST_LAT  = 16;
    localparam int SIDE_LAT = DIV_LAT + DST_LAT;
    localparam int PIPE_LAT = SIDE_LAT + 4;

    localparam int DEF_FRAME_WIDTH  = 1024;
    localparam int DEF_FRAME_HEIGHT = 768;

    typedef struct packed {
        logic [DATA_W-1:0]        focal_x;
        logic [DATA_W-1:0]        focal_y;
        logic signed [DATA_W-1:0] k1;
        logic signed [DATA_W-1:0] k2;
        logic signed [DATA_W-1:0] k3;
        logic signed [DATA_W-1:0] p1;
        logic signed [DATA_W-1:0] p2;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic zero;
        logic front;
        logic neg_x;
        logic neg_y;
    } side_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [39:0] term(input logic [63:0] prod, input logic neg,
                                                input int unsigned sh);
        logic [63:0] m;
        m = prod >> sh;
        return neg ? -$signed(m[39:0]) : $signed(m[39:0]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sh00_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < 40'shFF_8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] ssat(input logic neg, input logic ovf,
                                                input logic [31:0] q);
        if (ovf)
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        if (neg)
            return q[31] ? 32'sh8000_0000 : $signed(~q + 32'd1);
        return q[31] ? 32'sh7FFF_FFFF : $signed(q);
    endfunction

    function automatic logic [15:0] pix16(input logic signed [47:0] num);
        logic [47:0] a;
        logic [22:0] m;
        a = num[47] ? 48'(-num) : 48'(num);
        m = a[47:25];
        if (!num[47])
            return (m > 23'd32767) ? 16'h7FFF : m[15:0];
        return (m >= 23'd32768) ? 16'h8000 : (~m[15:0] + 16'd1);
    endfunction

endpackage

// ----- rtl/cpd_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Focal scales and distortion coefficients, written through a plain port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpd_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [cpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpd_pkg::DATA_W-1:0]   cfg_data,
    output cpd_pkg::cfg_t                cfg
);
    import cpd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x <= ONE_Q24;
            cfg_reg.focal_y <= ONE_Q24;
            cfg_reg.k1      <= '0;
            cfg_reg.k2      <= '0;
            cfg_reg.k3      <= '0;
            cfg_reg.p1      <= '0;
            cfg_reg.p2      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FOCAL_X: cfg_reg.focal_x <= cfg_data;
                REG_FOCAL_Y: cfg_reg.focal_y <= cfg_data;
                REG_K1:      cfg_reg.k1      <= $signed(cfg_data);
                REG_K2:      cfg_reg.k2      <= $signed(cfg_data);
                REG_K3:      cfg_reg.k3      <= $signed(cfg_data);
                REG_P1:      cfg_reg.p1      <= $signed(cfg_data);
                REG_P2:      cfg_reg.p2      <= $signed(cfg_data);
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/cpd_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, with overflow detect.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpd_div (
    input  logic                            clk,
    input  logic [2*cpd_pkg::DATA_W-1:0]    numer,
    input  logic [cpd_pkg::DATA_W-1:0]      denom,
    output logic [cpd_pkg::DATA_W-1:0]      quot,
    output logic                            ovf
);
    import cpd_pkg::*;

    localparam int NST = DATA_W;

    logic [DATA_W-1:0] rem_reg [0:NST];
    logic [DATA_W-1:0] low_reg [0:NST];
    logic [DATA_W-1:0] q_reg   [0:NST];
    logic [DATA_W-1:0] d_reg   [0:NST];
    logic              ovf_reg [0:NST];

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= numer[2*DATA_W-1:DATA_W];
        low_reg[0] <= numer[DATA_W-1:0];
        q_reg[0]   <= '0;
        d_reg[0]   <= denom;
        ovf_reg[0] <= (numer[2*DATA_W-1:DATA_W] >= denom);
    end

    for (genvar i = 1; i <= NST; i++)
    begin : g_stage
        logic [DATA_W:0] trial;
        logic            take;

        assign trial = {rem_reg[i-1], low_reg[i-1][DATA_W-1]};
        assign take  = (trial >= {1'b0, d_reg[i-1]});

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= take ? DATA_W'(trial - {1'b0, d_reg[i-1]}) : trial[DATA_W-1:0];
            low_reg[i] <= {low_reg[i-1][DATA_W-2:0], 1'b0};
            q_reg[i]   <= {q_reg[i-1][DATA_W-2:0], take};
            d_reg[i]   <= d_reg[i-1];
            ovf_reg[i] <= ovf_reg[i-1];
        end
    end

    assign quot = q_reg[NST];
    assign ovf  = ovf_reg[NST];

endmodule

// ----- rtl/cpd_distort.sv -----
// ----------------------------------------------------------------------------
// Distortion pipeline
// Radial gain, radial and tangential distortion on normalized coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpd_distort (
    input  logic                               clk,
    input  cpd_pkg::cfg_t                      cfg,
    input  logic [cpd_pkg::DATA_W-1:0]         qx,
    input  logic                               ovf_x,
    input  logic                               neg_x,
    input  logic [cpd_pkg::DATA_W-1:0]         qy,
    input  logic                               ovf_y,
    input  logic                               neg_y,
    output logic signed [cpd_pkg::DATA_W-1:0]  xt,
    output logic signed [cpd_pkg::DATA_W-1:0]  yt
);
    import cpd_pkg::*;

    localparam int NC = 13;

    logic signed [31:0] x_reg [0:8];
    logic signed [31:0] y_reg [0:8];
    logic [63:0]        px2_reg, py2_reg;
    logic [31:0]        r2_reg [2:12];
    logic [63:0]        prr_reg, pk1_reg;
    logic [31:0]        r4_reg;
    logic signed [39:0] t1_reg [4:7];
    logic [63:0]        pr6_reg, pk2_reg;
    logic [31:0]        r6_reg;
    logic signed [39:0] t2_reg;
    logic signed [39:0] t2b_reg;
    logic [63:0]        pk3_reg;
    logic signed [31:0] gain_reg;
    logic [63:0]        pxg_reg, pyg_reg;
    logic               nxg_reg, nyg_reg;
    logic signed [31:0] xr_reg [10:14];
    logic signed [31:0] yr_reg [10:14];
    logic [63:0]        pxy_reg, pxx_reg, pyy_reg;
    logic               nxy_reg;
    logic signed [31:0] xy_reg [12:13];
    logic signed [31:0] xx_reg, yy_reg;
    logic signed [31:0] sx_reg, sy_reg;
    logic [63:0]        pa_reg, pb_reg, pc_reg, pd_reg;
    logic               na_reg, nb_reg, nc_reg, nd_reg;
    logic signed [31:0] xt_reg, yt_reg;
    logic [64:0]        rsum;
    logic [39:0]        rsh;

    assign rsum = {1'b0, px2_reg} + {1'b0, py2_reg};
    assign rsh  = rsum[63:24];

    always_ff @(posedge clk)
    begin
        x_reg[0] <= ssat(neg_x, ovf_x, qx);
        y_reg[0] <= ssat(neg_y, ovf_y, qy);

        px2_reg <= mag32(x_reg[0]) * mag32(x_reg[0]);
        py2_reg <= mag32(y_reg[0]) * mag32(y_reg[0]);

        r2_reg[2] <= (rsh > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : rsh[31:0];

        prr_reg <= r2_reg[2] * r2_reg[2];
        pk1_reg <= mag32(cfg.k1) * r2_reg[2];

        r4_reg    <= sat32(term(prr_reg, 1'b0, 24));
        t1_reg[4] <= term(pk1_reg, cfg.k1[31], 28);

        pr6_reg <= r4_reg * r2_reg[4];
        pk2_reg <= mag32(cfg.k2) * r4_reg;

        r6_reg <= sat32(term(pr6_reg, 1'b0, 24));
        t2_reg <= term(pk2_reg, cfg.k2[31], 28);

        pk3_reg <= mag32(cfg.k3) * r6_reg;
        t2b_reg <= t2_reg;

        gain_reg <= sat32(40'sd16777216 + t1_reg[7] + t2b_reg + term(pk3_reg, cfg.k3[31], 28));

        pxg_reg <= mag32(x_reg[8]) * mag32(gain_reg);
        pyg_reg <= mag32(y_reg[8]) * mag32(gain_reg);
        nxg_reg <= x_reg[8][31] ^ gain_reg[31];
        nyg_reg <= y_reg[8][31] ^ gain_reg[31];

        xr_reg[10] <= sat32(term(pxg_reg, nxg_reg, 24));
        yr_reg[10] <= sat32(term(pyg_reg, nyg_reg, 24));

        pxy_reg <= mag32(xr_reg[10]) * mag32(yr_reg[10]);
        pxx_reg <= mag32(xr_reg[10]) * mag32(xr_reg[10]);
        pyy_reg <= mag32(yr_reg[10]) * mag32(yr_reg[10]);
        nxy_reg <= xr_reg[10][31] ^ yr_reg[10][31];

        xy_reg[12] <= sat32(term(pxy_reg, nxy_reg, 24));
        xx_reg     <= sat32(term(pxx_reg, 1'b0, 24));
        yy_reg     <= sat32(term(pyy_reg, 1'b0, 24));

        sx_reg     <= sat32($signed({8'd0, r2_reg[12]}) + $signed({7'd0, xx_reg, 1'b0}));
        sy_reg     <= sat32($signed({8'd0, r2_reg[12]}) + $signed({7'd0, yy_reg, 1'b0}));
        xy_reg[13] <= xy_reg[12];

        pa_reg <= mag32(cfg.p1) * mag32(xy_reg[13]);
        pb_reg <= mag32(cfg.p2) * mag32(sx_reg);
        pc_reg <= mag32(cfg.p1) * mag32(sy_reg);
        pd_reg <= mag32(cfg.p2) * mag32(xy_reg[13]);
        na_reg <= cfg.p1[31] ^ xy_reg[13][31];
        nb_reg <= cfg.p2[31] ^ sx_reg[31];
        nc_reg <= cfg.p1[31] ^ sy_reg[31];
        nd_reg <= cfg.p2[31] ^ xy_reg[13][31];

        xt_reg <= sat32($signed({{8{xr_reg[14][31]}}, xr_reg[14]})
                        + term(pa_reg, na_reg, 27) + term(pb_reg, nb_reg, 28));
        yt_reg <= sat32($signed({{8{yr_reg[14][31]}}, yr_reg[14]})
                        + term(pc_reg, nc_reg, 28) + term(pd_reg, nd_reg, 27));
    end

    for (genvar i = 1; i <= 8; i++)
    begin : g_xy
        always_ff @(posedge clk)
        begin
            x_reg[i] <= x_reg[i-1];
            y_reg[i] <= y_reg[i-1];
        end
    end

    for (genvar i = 3; i < 2 + NC - 2; i++)
    begin : g_r2
        always_ff @(posedge clk)
        begin
            r2_reg[i] <= r2_reg[i-1];
        end
    end

    for (genvar i = 5; i <= 7; i++)
    begin : g_t1
        always_ff @(posedge clk)
        begin
            t1_reg[i] <= t1_reg[i-1];
        end
    end

    for (genvar i = 11; i <= 14; i++)
    begin : g_xr
        always_ff @(posedge clk)
        begin
            xr_reg[i] <= xr_reg[i-1];
            yr_reg[i] <= yr_reg[i-1];
        end
    end

    assign xt = xt_reg;
    assign yt = yt_reg;

endmodule

// ----- rtl/camera_projection_with_distortion.sv -----
// ----------------------------------------------------------------------------
// Camera projection with lens distortion
// Throughput: one request per cycle, busy never rises; 32 divider stages set depth.
// Reset: asynchronous, clears valid bits and restores the register defaults.
// The receiver cannot stall; done pulses for one cycle per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_projection_with_distortion #(
    parameter int FRAME_WIDTH  = cpd_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = cpd_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_write,
    input  logic [cpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpd_pkg::DATA_W-1:0]          cfg_data,
    input  logic signed [cpd_pkg::DATA_W-1:0]   coord_forward,
    input  logic signed [cpd_pkg::DATA_W-1:0]   coord_left,
    input  logic signed [cpd_pkg::DATA_W-1:0]   coord_up,
    output logic                                done,
    output logic signed [15:0]                  pixel_x,
    output logic signed [15:0]                  pixel_y,
    output logic                                in_front,
    output logic                                zero_depth
);
    import cpd_pkg::*;

    localparam logic signed [14:0] WIDTH_S  = 15'(FRAME_WIDTH);
    localparam logic signed [47:0] HEIGHT_S = 48'(FRAME_HEIGHT) <<< 24;

    cfg_t cfg;

    logic                      a_valid_reg;
    logic signed [DATA_W-1:0]  a_fwd_reg, a_lft_reg, a_up_reg;
    side_t                     b_side_reg;
    logic [2*DATA_W-1:0]       b_nx_reg, b_ny_reg;
    logic [DATA_W-1:0]         b_fm_reg;
    side_t                     sd_reg [0:SIDE_LAT-1];
    logic [DATA_W-1:0]         qx, qy;
    logic                      ovf_x, ovf_y;
    logic signed [DATA_W-1:0]  xt, yt;
    side_t                     p_side_reg;
    logic signed [47:0]        p_numx_reg, p_numy_reg;
    logic signed [32:0]        xs;
    logic                      done_reg, front_reg, zero_reg;
    logic [15:0]               px_reg, py_reg;

    function automatic logic signed [32:0] xt_to_y(input logic signed [31:0] v);
        return 33'(v);
    endfunction

    cpd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_side_reg  <= '0;
            p_side_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg      <= start && !busy;
            b_side_reg.valid <= a_valid_reg;
            b_side_reg.zero  <= (a_fwd_reg == '0);
            b_side_reg.front <= !a_fwd_reg[DATA_W-1];
            b_side_reg.neg_x <= (a_lft_reg > 0) != a_fwd_reg[DATA_W-1];
            b_side_reg.neg_y <= a_up_reg[DATA_W-1] != a_fwd_reg[DATA_W-1];
            p_side_reg       <= sd_reg[SIDE_LAT-1];
            done_reg         <= p_side_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_fwd_reg <= coord_forward;
        a_lft_reg <= coord_left;
        a_up_reg  <= coord_up;

        b_nx_reg <= mag32(a_lft_reg) * cfg.focal_x;
        b_ny_reg <= mag32(a_up_reg) * cfg.focal_y;
        b_fm_reg <= mag32(a_fwd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIDE_LAT; i++)
            begin
                sd_reg[i] <= '0;
            end
        end
        else
        begin
            sd_reg[0] <= b_side_reg;
            for (int i = 1; i < SIDE_LAT; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    cpd_div u_div_x (
        .clk   (clk),
        .numer (b_nx_reg),
        .denom (b_fm_reg),
        .quot  (qx),
        .ovf   (ovf_x)
    );

    cpd_div u_div_y (
        .clk   (clk),
        .numer (b_ny_reg),
        .denom (b_fm_reg),
        .quot  (qy),
        .ovf   (ovf_y)
    );

    cpd_distort u_distort (
        .clk   (clk),
        .cfg   (cfg),
        .qx    (qx),
        .ovf_x (ovf_x),
        .neg_x (sd_reg[DIV_LAT-1].neg_x),
        .qy    (qy),
        .ovf_y (ovf_y),
        .neg_y (sd_reg[DIV_LAT-1].neg_y),
        .xt    (xt),
        .yt    (yt)
    );

    assign xs = 33'(xt) + 33'sd16777216;

    always_ff @(posedge clk)
    begin
        p_numx_reg <= 48'(xs * WIDTH_S);
        p_numy_reg <= HEIGHT_S - 48'(xt_to_y(yt) * WIDTH_S);

        front_reg <= p_side_reg.front;
        zero_reg  <= p_side_reg.zero;
        px_reg    <= p_side_reg.zero ? 16'd0 : pix16(p_numx_reg);
        py_reg    <= p_side_reg.zero ? 16'd0 : pix16(p_numy_reg);
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign pixel_x    = $signed(px_reg);
    assign pixel_y    = $signed(py_reg);
    assign in_front   = front_reg;
    assign zero_depth = zero_reg;

endmodule

// ----- rtl/cpd_checker.sv -----
// ----------------------------------------------------------------------------
// Projection port checker
// Latency, depth flag and zero-depth result checks seen at the ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "camera_projection_with_distortion_macros.svh"

module cpd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic signed [cpd_pkg::DATA_W-1:0] coord_forward,
    input logic                              done,
    input logic signed [15:0]                pixel_x,
    input logic signed [15:0]                pixel_y,
    input logic                              in_front,
    input logic                              zero_depth
);
    import cpd_pkg::*;

    `CPD_ASSERT_IMPL(a_lat, clk, rst_n, done, $past(start && !busy, PIPE_LAT))
    `CPD_ASSERT_IMPL(a_zero, clk, rst_n, done && zero_depth, pixel_x == '0 && pixel_y == '0 && in_front)
    `CPD_ASSERT_IMPL(a_front, clk, rst_n, done, in_front == !$past(coord_forward[DATA_W-1], PIPE_LAT))
    `CPD_ASSERT_IMPL(a_depth, clk, rst_n, done, zero_depth == ($past(coord_forward, PIPE_LAT) == '0))
    `CPD_ASSERT_NEXT(a_pulse, clk, rst_n, !$past(start && !busy, PIPE_LAT - 1), !done)

endmodule

bind camera_projection_with_distortion cpd_checker u_cpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .coord_forward (coord_forward),
    .done          (done),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .in_front      (in_front),
    .zero_depth    (zero_depth)
);
